>>> rtl/adts_pkg.sv
// shared types, codes and constants for the adts frame deframer
package adts_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 13;
  localparam int unsigned HdrW     = 56;
  localparam int unsigned HdrLenW  = 4;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 40;
  localparam int unsigned TuserOutW = 5;

  localparam logic [HdrLenW-1:0] FixedLen = 4'd7;
  localparam logic [HdrLenW-1:0] CrcLen   = 4'd9;
  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [3:0] SyncNibble = 4'hF;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_CRC     = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_DISCARD = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t              phase;
    logic [CountW-1:0]   byte_count;
    logic [HdrW-1:0]     header_bytes;
    logic [CountW-1:0]   length_held;
    logic [HdrLenW-1:0]  header_len;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    kind_t             byte_kind;
    logic              frame_start;
    logic              frame_end;
    logic              sync_error;
    logic              header_done;
    logic [1:0]        profile;
    logic [3:0]        sampling_index;
    logic [2:0]        channel_config;
    logic [CountW-1:0] frame_length;
    logic              prot_absent;
    logic [1:0]        raw_blocks;
  } result_t;

endpackage

>>> rtl/adts_step.sv
// next-state and result logic for one stream byte
module adts_step (
  input  adts_pkg::state_t         state,
  input  logic [adts_pkg::ByteW-1:0] data_byte,
  output adts_pkg::state_t         state_next,
  output adts_pkg::result_t        result
);

  logic [adts_pkg::CountW-1:0]  cnt_inc;
  logic [adts_pkg::HdrW-1:0]    hdr_new;
  logic [7:0]                   b0, b1, b2, b3, b4, b5, b6;
  logic [adts_pkg::CountW-1:0]  len;
  logic                         pa;
  logic [adts_pkg::HdrLenW-1:0] hl;
  logic                         sync_ok;
  logic                         len_short;

  assign cnt_inc = state.byte_count + adts_pkg::CountW'(1);

  // restart the header shift at the first byte of a frame attempt
  assign hdr_new = (state.byte_count == '0)
                 ? {{(adts_pkg::HdrW-adts_pkg::ByteW){1'b0}}, data_byte}
                 : {state.header_bytes[adts_pkg::HdrW-adts_pkg::ByteW-1:0], data_byte};

  assign b0 = hdr_new[55:48];
  assign b1 = hdr_new[47:40];
  assign b2 = hdr_new[39:32];
  assign b3 = hdr_new[31:24];
  assign b4 = hdr_new[23:16];
  assign b5 = hdr_new[15:8];
  assign b6 = hdr_new[7:0];

  assign len       = {b3[1:0], b4, b5[7:5]};
  assign pa        = b1[0];
  assign hl        = pa ? adts_pkg::FixedLen : adts_pkg::CrcLen;
  assign sync_ok   = (b0 == adts_pkg::SyncByte) && (b1[7:4] == adts_pkg::SyncNibble);
  assign len_short = len < adts_pkg::CountW'(hl);

  always_comb begin
    state_next = state;
    result     = '0;
    result.out_byte  = data_byte;
    result.byte_kind = adts_pkg::KIND_HEADER;

    case (state.phase)
      adts_pkg::PH_CRC: begin
        result.byte_kind      = adts_pkg::KIND_CRC;
        state_next.byte_count = cnt_inc;
        if (cnt_inc >= adts_pkg::CountW'(state.header_len)) begin
          if (state.length_held <= adts_pkg::CountW'(state.header_len)) begin
            result.frame_end      = 1'b1;
            state_next.phase      = adts_pkg::PH_HEADER;
            state_next.byte_count = '0;
          end else begin
            state_next.phase = adts_pkg::PH_PAYLOAD;
          end
        end
      end
      adts_pkg::PH_PAYLOAD: begin
        result.byte_kind      = adts_pkg::KIND_PAYLOAD;
        state_next.byte_count = cnt_inc;
        if (cnt_inc >= state.length_held) begin
          result.frame_end      = 1'b1;
          state_next.phase      = adts_pkg::PH_HEADER;
          state_next.byte_count = '0;
        end
      end
      default: begin
        // header phase, and any stray code behaves the same
        result.frame_start      = (state.byte_count == '0);
        state_next.header_bytes = hdr_new;
        state_next.byte_count   = cnt_inc;
        state_next.phase        = adts_pkg::PH_HEADER;
        if (cnt_inc >= adts_pkg::CountW'(adts_pkg::FixedLen)) begin
          if (!sync_ok || len_short) begin
            result.byte_kind      = adts_pkg::KIND_DISCARD;
            result.sync_error     = 1'b1;
            state_next.byte_count = '0;
          end else begin
            result.header_done    = 1'b1;
            result.profile        = b2[7:6];
            result.sampling_index = b2[5:2];
            result.channel_config = {b2[0], b3[7:6]};
            result.frame_length   = len;
            result.prot_absent    = pa;
            result.raw_blocks     = b6[1:0];
            state_next.length_held = len;
            state_next.header_len  = hl;
            if (!pa) begin
              state_next.phase = adts_pkg::PH_CRC;
            end else if (len == adts_pkg::CountW'(adts_pkg::FixedLen)) begin
              result.frame_end      = 1'b1;
              state_next.byte_count = '0;
            end else begin
              state_next.phase = adts_pkg::PH_PAYLOAD;
            end
          end
        end
      end
    endcase
  end

endmodule

>>> rtl/adts_frame_deframer.sv
// adts deframer top level: parse state, result register and stream ports
// One byte enters per beat and one registered result beat leaves per byte, so
// the block sustains one byte per clock; the only limit is the output register, which
// takes a new byte whenever it is empty or its beat is being taken in the same cycle.
// Each byte is classified as header, crc, payload or discarded; header fields appear on
// the seventh header byte only (header_done), and zero on every other beat. A bad sync
// word or a frame length shorter than the header discards that seventh byte with
// sync_error and hunting resumes at the next byte. tlast marks the last byte of a frame.
module adts_frame_deframer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [adts_pkg::TdataInW-1:0]       s_axis_tdata,  // [7:0] data_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] out_byte, [9:8] profile, [13:10] sampling_index, [16:14] channel_config,
  // [29:17] frame_length, [30] prot_absent, [32:31] raw_blocks, [39:33] zero
  output logic [adts_pkg::TdataOutW-1:0]      m_axis_tdata,
  // [1:0] byte_kind, [2] frame_start, [3] sync_error, [4] header_done
  output logic [adts_pkg::TuserOutW-1:0]      m_axis_tuser,
  output logic                                m_axis_tlast
);

  adts_pkg::state_t  state;
  adts_pkg::state_t  state_next;
  adts_pkg::result_t result_next;
  adts_pkg::result_t result;
  logic              take;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  adts_step u_step (
    .state      (state),
    .data_byte  (s_axis_tdata[adts_pkg::ByteW-1:0]),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= adts_pkg::PH_HEADER;
      state.byte_count   <= '0;
      state.header_bytes <= '0;
      state.length_held  <= '0;
      state.header_len   <= adts_pkg::FixedLen;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign m_axis_tdata = {7'd0, result.raw_blocks, result.prot_absent,
                         result.frame_length, result.channel_config,
                         result.sampling_index, result.profile, result.out_byte};
  assign m_axis_tuser = {result.header_done, result.sync_error, result.frame_start,
                         result.byte_kind};
  assign m_axis_tlast = result.frame_end;

endmodule

>>> test/tb_adts_frame_deframer.sv
// self-checking testbench for the adts frame deframer: frame stimulus, byte predictor, checker
module tb_adts_frame_deframer;

  localparam int StallLimit = 4000;
  localparam int HoldCycles = 300;
  localparam int RandomBytes = 700;

  // header fault to inject
  localparam int FaultNone   = 0;
  localparam int FaultByte0  = 1;
  localparam int FaultNibble = 2;

  // how the header fields of a frame are filled
  localparam int FillRandom = 0;
  localparam int FillOnes   = 1;
  localparam int FillZeros  = 2;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [adts_pkg::TdataInW-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [adts_pkg::TdataOutW-1:0] m_axis_tdata;
  logic [adts_pkg::TuserOutW-1:0] m_axis_tuser;
  logic                           m_axis_tlast;

  adts_frame_deframer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // parser state mirrored by the predictor
  adts_pkg::phase_t                  parse_phase = adts_pkg::PH_HEADER;
  logic [adts_pkg::CountW-1:0]       frame_pos   = '0;
  logic [adts_pkg::HdrW-1:0]         hdr_shift   = '0;
  logic [adts_pkg::CountW-1:0]       held_len    = '0;
  logic [adts_pkg::HdrLenW-1:0]      hdr_len     = adts_pkg::FixedLen;

  adts_pkg::result_t expected_beats[$];

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  bit hold_request = 1'b0;

  int errors = 0;
  int bytes_sent = 0;
  int beats_checked = 0;
  int headers_seen = 0;
  int sync_errors_seen = 0;
  int frames_seen = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // classify one byte and advance the parse state
  function automatic adts_pkg::result_t deframe_byte(input logic [7:0] b);
    adts_pkg::result_t r;
    logic [7:0] b0, b1, b2, b3, b4, b5, b6;
    logic [adts_pkg::CountW-1:0] flen;
    logic [adts_pkg::HdrLenW-1:0] hl;
    logic sync_ok;
    r = '0;
    r.out_byte = b;
    r.byte_kind = adts_pkg::KIND_HEADER;
    case (parse_phase)
      adts_pkg::PH_CRC: begin
        r.byte_kind = adts_pkg::KIND_CRC;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos >= hdr_len) begin
          if (held_len <= hdr_len) begin
            r.frame_end = 1'b1;
            parse_phase = adts_pkg::PH_HEADER;
            frame_pos = '0;
          end else begin
            parse_phase = adts_pkg::PH_PAYLOAD;
          end
        end
      end
      adts_pkg::PH_PAYLOAD: begin
        r.byte_kind = adts_pkg::KIND_PAYLOAD;
        frame_pos = frame_pos + 1'b1;
        if (frame_pos >= held_len) begin
          r.frame_end = 1'b1;
          parse_phase = adts_pkg::PH_HEADER;
          frame_pos = '0;
        end
      end
      default: begin
        if (frame_pos == 0) begin
          r.frame_start = 1'b1;
          hdr_shift = '0;
        end
        hdr_shift = {hdr_shift[adts_pkg::HdrW-9:0], b};
        frame_pos = frame_pos + 1'b1;
        parse_phase = adts_pkg::PH_HEADER;
        if (frame_pos >= adts_pkg::FixedLen) begin
          {b0, b1, b2, b3, b4, b5, b6} = hdr_shift;
          flen = {b3[1:0], b4, b5[7:5]};
          hl = b1[0] ? adts_pkg::FixedLen : adts_pkg::CrcLen;
          sync_ok = (b0 == adts_pkg::SyncByte) && (b1[7:4] == adts_pkg::SyncNibble);
          if (!sync_ok || flen < hl) begin
            r.byte_kind = adts_pkg::KIND_DISCARD;
            r.sync_error = 1'b1;
            frame_pos = '0;
          end else begin
            r.header_done = 1'b1;
            r.profile = b2[7:6];
            r.sampling_index = b2[5:2];
            r.channel_config = {b2[0], b3[7:6]};
            r.frame_length = flen;
            r.prot_absent = b1[0];
            r.raw_blocks = b6[1:0];
            held_len = flen;
            hdr_len = hl;
            if (!b1[0]) begin
              parse_phase = adts_pkg::PH_CRC;
            end else if (flen == adts_pkg::FixedLen) begin
              r.frame_end = 1'b1;
              frame_pos = '0;
            end else begin
              parse_phase = adts_pkg::PH_PAYLOAD;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_beats.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  // one adts frame; crc and payload follow only when the header is sound
  task automatic send_adts_frame(input logic pa, input logic [12:0] flen, input int fault,
                                 input int fill);
    logic [31:0] f;
    logic [7:0] h[7];
    logic [3:0] nibble;
    f = (fill == FillOnes) ? '1 : (fill == FillZeros) ? '0 : $urandom;
    nibble = (fault == FaultNibble) ? 4'($urandom_range(0, 14)) : adts_pkg::SyncNibble;
    h[0] = (fault == FaultByte0) ? 8'($urandom_range(0, 254)) : adts_pkg::SyncByte;
    h[1] = {nibble, f[11], f[13:12], pa};
    h[2] = {f[1:0], f[5:2], f[14], f[8]};
    h[3] = {f[7:6], f[15], f[16], f[17], f[18], flen[12:11]};
    h[4] = flen[10:3];
    h[5] = {flen[2:0], f[29:25]};
    h[6] = {f[24:19], f[10:9]};
    for (int i = 0; i < 7; i++) send_byte(h[i]);
    if (fault == FaultNone && flen >= (pa ? adts_pkg::FixedLen : adts_pkg::CrcLen))
      repeat (int'(flen) - 7) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_headers();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_adts_frame(1'b1, 13'd7, FaultNone, FillOnes);    // header only, no crc
    send_adts_frame(1'b0, 13'd9, FaultNone, FillZeros);   // header and crc, no payload
    send_adts_frame(1'b0, 13'd8, FaultNone, FillRandom);  // length shorter than crc header
    send_adts_frame(1'b1, 13'd0, FaultByte0, FillRandom);
    send_adts_frame(1'b1, 13'd8, FaultNibble, FillRandom);
  endtask

  task automatic test_random_stream();
    int start_count;
    int next_switch;
    int r;
    logic pa;
    int hl;
    start_count = bytes_sent;
    next_switch = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      if (bytes_sent >= next_switch) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
        next_switch = bytes_sent + 150;
      end
      r = $urandom_range(0, 99);
      pa = 1'($urandom_range(0, 1));
      hl = pa ? 7 : 9;
      if (r < 70) begin
        if ($urandom_range(0, 9) == 0)
          send_adts_frame(pa, 13'(hl + $urandom_range(0, 250)), FaultNone, FillRandom);
        else
          send_adts_frame(pa, 13'(hl + $urandom_range(0, 12)), FaultNone, FillRandom);
      end else if (r < 80) begin
        send_adts_frame(pa, 13'($urandom_range(0, 8191)),
                        $urandom_range(0, 1) ? FaultByte0 : FaultNibble, FillRandom);
      end else if (r < 88) begin
        send_adts_frame(pa, 13'($urandom_range(0, hl - 1)), FaultNone, FillRandom);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver stalls for a long stretch while the frame keeps coming
  task automatic test_output_hold();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_request = 1'b1;
    send_adts_frame(1'b0, 13'd60, FaultNone, FillRandom);
  endtask

  task automatic test_long_frame();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    send_adts_frame(1'b1, 13'd300, FaultNone, FillRandom);
  endtask

  initial begin : sink
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_idle) stall = pick_gap();
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    adts_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected, out_byte %0h", m_axis_tdata[7:0]);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
        check_field("profile", want.profile, m_axis_tdata[9:8]);
        check_field("sampling_index", want.sampling_index, m_axis_tdata[13:10]);
        check_field("channel_config", want.channel_config, m_axis_tdata[16:14]);
        check_field("frame_length", want.frame_length, m_axis_tdata[29:17]);
        check_field("prot_absent", want.prot_absent, m_axis_tdata[30]);
        check_field("raw_blocks", want.raw_blocks, m_axis_tdata[32:31]);
        check_field("tdata pad", 0, m_axis_tdata[39:33]);
        check_field("byte_kind", want.byte_kind, m_axis_tuser[1:0]);
        check_field("frame_start", want.frame_start, m_axis_tuser[2]);
        check_field("sync_error", want.sync_error, m_axis_tuser[3]);
        check_field("header_done", want.header_done, m_axis_tuser[4]);
        check_field("frame_end", want.frame_end, m_axis_tlast);
        beats_checked++;
        if (m_axis_tuser[4]) headers_seen++;
        if (m_axis_tuser[3]) sync_errors_seen++;
        if (m_axis_tlast) frames_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_headers();
    test_random_stream();
    test_output_hold();
    test_long_frame();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("checked %0d result beats for %0d bytes sent", beats_checked, bytes_sent);
    $display("saw %0d good headers, %0d sync or length errors, %0d complete frames",
             headers_seen, sync_errors_seen, frames_seen);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
